// ===== sv/cfst_pkg.sv =====
// ============================================================================
// cfst_pkg
// Shared types, codes and helpers of the CAN frame to SLCAN text encoder.
// ============================================================================
package cfst_pkg;

    localparam int IdWidth    = 29;
    localparam int LenWidth   = 4;
    localparam int DataWidth  = 64;
    localparam int TsWidth    = 16;
    localparam int CharWidth  = 8;
    localparam int CntWidth   = 4;   // up to 16 data digits per line

    localparam logic [LenWidth-1:0]  MaxLen     = 4'd8;
    localparam logic [CharWidth-1:0] CharStdDat = 8'h74;  // 't'
    localparam logic [CharWidth-1:0] CharStdRem = 8'h72;  // 'r'
    localparam logic [CharWidth-1:0] CharExtDat = 8'h54;  // 'T'
    localparam logic [CharWidth-1:0] CharExtRem = 8'h52;  // 'R'
    localparam logic [CharWidth-1:0] CharZero   = 8'h30;
    localparam logic [CharWidth-1:0] CharUpperA = 8'h41;
    localparam logic [CharWidth-1:0] CharCr     = 8'h0D;
    localparam logic [CharWidth-1:0] HexTen     = 8'd10;

    // which field of the line the datapath sends next
    typedef enum logic [2:0] {
        SEL_TYPE = 3'd0,
        SEL_ID   = 3'd1,
        SEL_LEN  = 3'd2,
        SEL_DATA = 3'd3,
        SEL_TS   = 3'd4,
        SEL_CR   = 3'd5
    } t_sel;

    typedef struct packed {
        logic take;      // idle: frame channel ready
        logic emit;      // load one char into the output register
        t_sel sel;
    } t_cmd;

    typedef struct packed {
        logic frame_acc;   // frame accepted this cycle
        logic out_free;    // output register can take a char
        logic has_data;    // data frame with nonzero length
        logic ts_en;
        logic field_last;  // current char ends the selected field
    } t_status;

    function automatic logic [CharWidth-1:0] hex_char(input logic [3:0] d);
        logic [CharWidth-1:0] w;
        w = {4'b0000, d};
        return (d <= 4'd9) ? (CharZero + w) : (CharUpperA + w - HexTen);
    endfunction

endpackage

// ===== sv/cfst_ifs.sv =====
// ============================================================================
// cfst_ifs
// Valid/ready channels of the encoder: frame in, text out, config write.
// ============================================================================
interface cfst_frame_if;
    logic                           valid;
    logic                           ready;
    logic                           is_extended;
    logic                           is_remote;
    logic [cfst_pkg::IdWidth-1:0]   identifier;
    logic [cfst_pkg::LenWidth-1:0]  length_code;
    logic [cfst_pkg::DataWidth-1:0] data_bytes;
    logic [cfst_pkg::TsWidth-1:0]   timestamp;

    modport source (output valid, is_extended, is_remote, identifier, length_code,
                    data_bytes, timestamp, input ready);
    modport sink   (input valid, is_extended, is_remote, identifier, length_code,
                    data_bytes, timestamp, output ready);
endinterface

interface cfst_text_if;
    logic                           valid;
    logic                           ready;
    logic [cfst_pkg::CharWidth-1:0] text_char;
    logic                           is_last;

    modport source (output valid, text_char, is_last, input ready);
    modport sink   (input valid, text_char, is_last, output ready);
endinterface

interface cfst_cfg_if;
    logic valid;
    logic ready;
    logic timestamp_enable;

    modport source (output valid, timestamp_enable, input ready);
    modport sink   (input valid, timestamp_enable, output ready);
endinterface

// ===== sv/cfst_datapath.sv =====
// ============================================================================
// cfst_datapath
// Frame capture, digit counter, character select and output register.
// ============================================================================
module cfst_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfst_pkg::t_cmd    i_cmd,
    output cfst_pkg::t_status o_status,
    cfst_frame_if.sink        i_frame,
    cfst_text_if.source       o_text,
    cfst_cfg_if.sink          i_cfg
);

    logic                            r_ext, r_rem, r_ts_en;
    logic [cfst_pkg::IdWidth-1:0]    r_id;
    logic [cfst_pkg::LenWidth-1:0]   r_len;
    logic [cfst_pkg::DataWidth-1:0]  r_data;
    logic [cfst_pkg::TsWidth-1:0]    r_ts;
    logic [cfst_pkg::CntWidth-1:0]   r_cnt, n_cnt;
    logic                            r_out_valid, n_out_valid;
    logic [cfst_pkg::CharWidth-1:0]  r_out_char, n_out_char;
    logic                            r_out_last, n_out_last;

    logic                            frame_acc;
    logic [31:0]                     id_word;
    logic [2:0]                      id_idx;
    logic [3:0]                      nib;
    logic [cfst_pkg::LenWidth:0]     data_end;
    logic [cfst_pkg::CntWidth-1:0]   id_end;
    logic                            field_last;

    assign frame_acc     = i_frame.valid && i_cmd.take;
    assign i_frame.ready = i_cmd.take;
    assign i_cfg.ready   = 1'b1;

    // standard ids show only the low 11 bits
    assign id_word  = r_ext ? {3'b000, r_id} : {21'd0, r_id[10:0]};
    assign id_end   = r_ext ? 4'd7 : 4'd2;
    assign id_idx   = id_end[2:0] - r_cnt[2:0];
    assign data_end = {r_len, 1'b0} - 5'd1;

    always_comb begin
        nib        = 4'h0;
        field_last = 1'b1;
        n_out_char = cfst_pkg::CharCr;
        case (i_cmd.sel)
            cfst_pkg::SEL_TYPE: begin
                n_out_char = r_ext ? (r_rem ? cfst_pkg::CharExtRem : cfst_pkg::CharExtDat)
                                   : (r_rem ? cfst_pkg::CharStdRem : cfst_pkg::CharStdDat);
            end
            cfst_pkg::SEL_ID: begin
                nib        = id_word[{id_idx, 2'b00} +: 4];
                field_last = (r_cnt == id_end);
                n_out_char = cfst_pkg::hex_char(nib);
            end
            cfst_pkg::SEL_LEN: begin
                n_out_char = cfst_pkg::CharZero + {4'b0000, r_len};
            end
            cfst_pkg::SEL_DATA: begin
                // high nibble of each byte first
                nib        = r_data[{r_cnt[3:1], ~r_cnt[0], 2'b00} +: 4];
                field_last = (r_cnt == data_end[cfst_pkg::CntWidth-1:0]);
                n_out_char = cfst_pkg::hex_char(nib);
            end
            cfst_pkg::SEL_TS: begin
                nib        = r_ts[{2'd3 - r_cnt[1:0], 2'b00} +: 4];
                field_last = (r_cnt == 4'd3);
                n_out_char = cfst_pkg::hex_char(nib);
            end
            cfst_pkg::SEL_CR: begin
                n_out_char = cfst_pkg::CharCr;
            end
            default: begin
                n_out_char = cfst_pkg::CharCr;
            end
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_text.ready;
        n_out_last  = (i_cmd.sel == cfst_pkg::SEL_CR);
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_cnt       = field_last ? '0 : r_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_ts_en     <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_ts_en <= i_cfg.timestamp_enable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_acc) begin
            r_ext  <= i_frame.is_extended;
            r_rem  <= i_frame.is_remote;
            r_id   <= i_frame.identifier;
            r_len  <= (i_frame.length_code > cfst_pkg::MaxLen) ? cfst_pkg::MaxLen
                                                               : i_frame.length_code;
            r_data <= i_frame.data_bytes;
            r_ts   <= i_frame.timestamp;
        end
        if (i_cmd.emit) begin
            r_out_char <= n_out_char;
            r_out_last <= n_out_last;
        end
    end

    assign o_text.valid     = r_out_valid;
    assign o_text.text_char = r_out_char;
    assign o_text.is_last   = r_out_last;

    assign o_status.frame_acc  = frame_acc;
    assign o_status.out_free   = !r_out_valid || o_text.ready;
    assign o_status.has_data   = !r_rem && (r_len != '0);
    assign o_status.ts_en      = r_ts_en;
    assign o_status.field_last = field_last;

`ifndef SYNTH
    a_last_is_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_char == cfst_pkg::CharCr)
        else $error("last mark on a char other than CR");
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("emitted char not held in output register");
    a_len_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_acc |=> r_len <= cfst_pkg::MaxLen)
        else $error("length code not clamped");
    a_id_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && i_cmd.sel == cfst_pkg::SEL_ID |-> r_cnt <= id_end)
        else $error("identifier digit counter overran");
`endif

endmodule

// ===== sv/cfst_ctrl.sv =====
// ============================================================================
// cfst_ctrl
// Line sequencer: walks the fields of one SLCAN line, one char per step.
// ============================================================================
module cfst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfst_pkg::t_status i_status,
    output cfst_pkg::t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_TYPE = 7'b0000010,
        S_ID   = 7'b0000100,
        S_LEN  = 7'b0001000,
        S_DATA = 7'b0010000,
        S_TS   = 7'b0100000,
        S_CR   = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    t_state        after_body;
    logic          emit;
    cfst_pkg::t_sel sel;

    assign emit       = (r_state != S_IDLE) && i_status.out_free;
    assign after_body = i_status.ts_en ? S_TS : S_CR;

    always_comb begin
        n_state = r_state;
        sel     = cfst_pkg::SEL_CR;
        case (r_state)
            S_IDLE: begin
                if (i_status.frame_acc) n_state = S_TYPE;
            end
            S_TYPE: begin
                sel = cfst_pkg::SEL_TYPE;
                if (emit) n_state = S_ID;
            end
            S_ID: begin
                sel = cfst_pkg::SEL_ID;
                if (emit && i_status.field_last) n_state = S_LEN;
            end
            S_LEN: begin
                sel = cfst_pkg::SEL_LEN;
                if (emit) n_state = i_status.has_data ? S_DATA : after_body;
            end
            S_DATA: begin
                sel = cfst_pkg::SEL_DATA;
                if (emit && i_status.field_last) n_state = after_body;
            end
            S_TS: begin
                sel = cfst_pkg::SEL_TS;
                if (emit && i_status.field_last) n_state = S_CR;
            end
            S_CR: begin
                sel = cfst_pkg::SEL_CR;
                if (emit) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd.sel  = sel;
    assign o_cmd.take = (r_state == S_IDLE);
    assign o_cmd.emit = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.frame_acc |=> r_state == S_TYPE)
        else $error("accepted frame did not start a line");
    a_cr_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CR && emit |=> r_state == S_IDLE)
        else $error("line did not close after CR");
`endif

endmodule

// ===== sv/can_frame_to_slcan_text.sv =====
// ============================================================================
// can_frame_to_slcan_text
// Encodes one received CAN frame as one SLCAN ASCII line, one char per item.
// ============================================================================
// One frame item in, 6 to 31 char items out: type letter (t/r/T/R), id in
// upper-case hex (3 or 8 digits), length digit (code clamped to 8), two hex
// digits per data byte for data frames, four timestamp digits when
// timestamp_enable is set, then CR flagged with is_last. The sequencer sends
// one char per cycle from the output register while the sink is ready: it
// first takes the frame, then sends the chars of the line in turn. A new
// frame is taken only once the CR has been loaded into the output register;
// back-pressure on the text side simply stretches the line. Write
// timestamp_enable only between lines.
// ============================================================================
module can_frame_to_slcan_text (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfst_frame_if.sink  i_frame,
    cfst_text_if.source o_text,
    cfst_cfg_if.sink    i_cfg
);

    // controller <-> datapath
    cfst_pkg::t_cmd    cmd;
    cfst_pkg::t_status status;

    // field sequencer
    cfst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // capture regs, digit select, output register, config register
    cfst_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_frame  (i_frame),
        .o_text   (o_text),
        .i_cfg    (i_cfg)
    );

endmodule
